// ===== hdl/ucp_pkg.sv =====
// Package for the UTF-8 / code page transcoder: command codes, constants,
// the decoder status struct and a small helper function.
// No dependencies.
package ucp_pkg;

    localparam int TABLE_ENTRIES_DEF = 128;
    localparam int POINT_W           = 21;
    localparam int VALUE_W           = 16;
    localparam int BYTE_W            = 8;
    localparam int INDEX_W           = 7;
    localparam int CMD_W             = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DECODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd2;

    localparam logic [BYTE_W-1:0]  NO_MAP_BYTE = 8'h7F;
    localparam logic [BYTE_W-1:0]  HIGH_BASE   = 8'h80;
    localparam logic [VALUE_W-1:0] REPLACEMENT = 16'hFFFD;
    localparam logic [POINT_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [POINT_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [POINT_W-1:0] MAX_POINT   = 21'h10FFFF;

    typedef struct packed {
        logic              bad_cont;
        logic              lead_used;
        logic              lead_emit;
        logic [BYTE_W-1:0] lead_byte;
        logic              lead_end;
        logic              seq_done;
    } dec_info_t;

    function automatic logic [POINT_W-1:0] min_for_extra(input logic [1:0] extra);
        logic [POINT_W-1:0] m;
        begin
            case (extra)
                2'd1:    m = 21'h000080;
                2'd2:    m = 21'h000800;
                2'd3:    m = 21'h010000;
                default: m = 21'h000000;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== hdl/ucp_channels.sv =====
// Channel interfaces of the transcoder: request and response, valid/ready.
// Depends on ucp_pkg.
interface ucp_req_if;
    logic                          valid;
    logic                          ready;
    logic [ucp_pkg::CMD_W-1:0]     cmd;
    logic [ucp_pkg::BYTE_W-1:0]    byte_in;
    logic [ucp_pkg::INDEX_W-1:0]   entry_index;
    logic [ucp_pkg::VALUE_W-1:0]   entry_value;

    modport source (output valid, cmd, byte_in, entry_index, entry_value, input ready);
    modport sink   (input valid, cmd, byte_in, entry_index, entry_value, output ready);
endinterface

interface ucp_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ucp_pkg::BYTE_W-1:0]    out_byte;
    logic                          last_of_run;
    logic                          string_end;

    modport source (output valid, out_byte, last_of_run, string_end, input ready);
    modport sink   (input valid, out_byte, last_of_run, string_end, output ready);
endinterface

// ===== hdl/ucp_table.sv =====
// Code table memory: one write port, one registered read port, per-entry valid flags.
// Entries never written read as zero. Depends on ucp_pkg.
module ucp_table #(
    parameter int TABLE_ENTRIES = ucp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
    input  logic [ucp_pkg::VALUE_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
    output logic [ucp_pkg::VALUE_W-1:0]   rd_data
);

    logic [ucp_pkg::VALUE_W-1:0] mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]    vld_reg;
    logic [ucp_pkg::VALUE_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/ucp_dec.sv =====
// UTF-8 decoder state: partial code point, pending and sequence byte counts,
// byte classification and the range check of a completed code point. Depends on ucp_pkg.
module ucp_dec (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [ucp_pkg::BYTE_W-1:0]    byte_in,
    output ucp_pkg::dec_info_t            info,
    output logic [ucp_pkg::POINT_W-1:0]   point,
    output logic                          point_ok
);

    logic [ucp_pkg::POINT_W-1:0] partial_reg, partial_next;
    logic [1:0]                  pend_reg, pend_next;
    logic [1:0]                  extra_reg, extra_next;
    logic [1:0]                  lead_extra;
    logic [ucp_pkg::POINT_W-1:0] lead_point;
    logic                        is_cont;
    logic                        idle_seq;

    assign idle_seq = (pend_reg == 2'd0);
    assign is_cont  = (byte_in[7:6] == 2'b10);

    always_comb
    begin
        info.lead_emit = 1'b1;
        info.lead_byte = ucp_pkg::NO_MAP_BYTE;
        info.lead_end  = 1'b0;
        lead_extra     = 2'd0;
        lead_point     = '0;
        case (byte_in) inside
            8'h00:
            begin
                info.lead_byte = 8'h00;
                info.lead_end  = 1'b1;
            end
            [8'h01:8'h7F]:
            begin
                info.lead_byte = byte_in;
            end
            [8'hC0:8'hDF]:
            begin
                info.lead_emit = 1'b0;
                lead_extra     = 2'd1;
                lead_point     = ucp_pkg::POINT_W'(byte_in[4:0]);
            end
            [8'hE0:8'hEF]:
            begin
                info.lead_emit = 1'b0;
                lead_extra     = 2'd2;
                lead_point     = ucp_pkg::POINT_W'(byte_in[3:0]);
            end
            [8'hF0:8'hF7]:
            begin
                info.lead_emit = 1'b0;
                lead_extra     = 2'd3;
                lead_point     = ucp_pkg::POINT_W'(byte_in[2:0]);
            end
            default:
            begin
                info.lead_byte = ucp_pkg::NO_MAP_BYTE;
            end
        endcase
        info.bad_cont  = !idle_seq && !is_cont;
        info.lead_used = idle_seq || !is_cont;
        info.seq_done  = !idle_seq && is_cont && (pend_reg == 2'd1);
    end

    always_comb
    begin
        partial_next = partial_reg;
        pend_next    = pend_reg;
        extra_next   = extra_reg;
        if (step)
        begin
            if (info.lead_used)
            begin
                if (info.lead_emit)
                begin
                    pend_next = 2'd0;
                end
                else
                begin
                    partial_next = lead_point;
                    extra_next   = lead_extra;
                    pend_next    = lead_extra;
                end
            end
            else
            begin
                partial_next = {partial_reg[ucp_pkg::POINT_W-7:0], byte_in[5:0]};
                pend_next    = pend_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pend_reg    <= 2'd0;
            extra_reg   <= 2'd0;
        end
        else
        begin
            partial_reg <= partial_next;
            pend_reg    <= pend_next;
            extra_reg   <= extra_next;
        end
    end

    assign point    = partial_reg;
    assign point_ok = (partial_reg >= ucp_pkg::min_for_extra(extra_reg))
                   && (partial_reg <= ucp_pkg::MAX_POINT)
                   && !((partial_reg >= ucp_pkg::SURR_LO) && (partial_reg <= ucp_pkg::SURR_HI));

endmodule

// ===== hdl/utf8_codepage_transcoder.sv =====
// Top level of the UTF-8 / code page transcoder: sequencer, table search and output register.
// Depends on ucp_pkg, ucp_channels, ucp_table and ucp_dec.
//
//   Channel  Role  Transaction
//   req      sink  one command: load entry, decode UTF-8 byte or encode code-page byte
//   rsp      src   one output byte with last_of_run and string_end flags
//
// A load writes its table entry when accepted. A completed decode sequence searches
// the table one entry per cycle through the single read port of the table memory.
// Reset clears the table valid flags at once; no clearing pass.
// req.ready is high only while the sequencer is idle; rsp back-pressure holds emission.
module utf8_codepage_transcoder #(
    parameter int TABLE_ENTRIES = ucp_pkg::TABLE_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ucp_req_if.sink   req,
    ucp_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_LOOKUP = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ucp_pkg::BYTE_W-1:0] res_byte_reg [3];
    logic [ucp_pkg::BYTE_W-1:0] res_byte_next [3];
    logic [2:0]                 res_end_reg, res_end_next;
    logic [1:0]                 res_cnt_reg, res_cnt_next;
    logic [1:0]                 res_idx_reg, res_idx_next;
    logic [CNT_W-1:0]           search_cnt_reg, search_cnt_next;
    logic                       cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]           cmp_idx_reg, cmp_idx_next;

    logic                       out_valid_reg, out_valid_next;
    logic [ucp_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_end_reg, out_end_next;

    logic                       accept;
    logic                       dec_step;
    logic                       tbl_wr_en;
    logic                       tbl_rd_en;
    logic [IDX_W-1:0]           tbl_rd_addr;
    logic [ucp_pkg::VALUE_W-1:0] tbl_rd_data;
    logic [ucp_pkg::VALUE_W-1:0] enc_value;
    ucp_pkg::dec_info_t         dec_info;
    logic [ucp_pkg::POINT_W-1:0] dec_point;
    logic                       dec_point_ok;
    logic                       hit;
    logic                       out_free;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign dec_step  = accept && (req.cmd == ucp_pkg::CMD_DECODE);
    assign tbl_wr_en = accept && (req.cmd == ucp_pkg::CMD_LOAD);

    ucp_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (req.entry_index[IDX_W-1:0]),
        .wr_data (req.entry_value),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    ucp_dec u_dec (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (dec_step),
        .byte_in  (req.byte_in),
        .info     (dec_info),
        .point    (dec_point),
        .point_ok (dec_point_ok)
    );

    assign hit = cmp_pend_reg && (tbl_rd_data == dec_point[ucp_pkg::VALUE_W-1:0])
              && (dec_point[ucp_pkg::POINT_W-1:ucp_pkg::VALUE_W] == '0);
    assign enc_value = (tbl_rd_data == '0) ? ucp_pkg::REPLACEMENT : tbl_rd_data;
    assign out_free  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        res_byte_next   = res_byte_reg;
        res_end_next    = res_end_reg;
        res_cnt_next    = res_cnt_reg;
        res_idx_next    = res_idx_reg;
        search_cnt_next = search_cnt_reg;
        cmp_pend_next   = cmp_pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = search_cnt_reg[IDX_W-1:0];
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;

        case (state_reg)
            ST_IDLE:
            begin
                res_idx_next = 2'd0;
                res_end_next = 3'b000;
                if (accept)
                begin
                    case (req.cmd)
                        ucp_pkg::CMD_DECODE:
                        begin
                            if (dec_info.bad_cont)
                            begin
                                res_byte_next[0] = ucp_pkg::NO_MAP_BYTE;
                                res_byte_next[1] = dec_info.lead_byte;
                                res_end_next[1]  = dec_info.lead_end;
                                res_cnt_next     = dec_info.lead_emit ? 2'd2 : 2'd1;
                                state_next       = ST_EMIT;
                            end
                            else if (dec_info.lead_used)
                            begin
                                if (dec_info.lead_emit)
                                begin
                                    res_byte_next[0] = dec_info.lead_byte;
                                    res_end_next[0]  = dec_info.lead_end;
                                    res_cnt_next     = 2'd1;
                                    state_next       = ST_EMIT;
                                end
                            end
                            else if (dec_info.seq_done)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        ucp_pkg::CMD_ENCODE:
                        begin
                            if (req.byte_in[7])
                            begin
                                tbl_rd_en   = 1'b1;
                                tbl_rd_addr = req.byte_in[IDX_W-1:0];
                                state_next  = ST_LOOKUP;
                            end
                            else
                            begin
                                res_byte_next[0] = req.byte_in;
                                res_cnt_next     = 2'd1;
                                state_next       = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (dec_point_ok)
                begin
                    search_cnt_next = '0;
                    cmp_pend_next   = 1'b0;
                    state_next      = ST_SEARCH;
                end
                else
                begin
                    res_byte_next[0] = ucp_pkg::NO_MAP_BYTE;
                    res_cnt_next     = 2'd1;
                    state_next       = ST_EMIT;
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    res_byte_next[0] = ucp_pkg::HIGH_BASE | ucp_pkg::BYTE_W'(cmp_idx_reg);
                    res_cnt_next     = 2'd1;
                    cmp_pend_next    = 1'b0;
                    state_next       = ST_EMIT;
                end
                else if (search_cnt_reg == CNT_W'(TABLE_ENTRIES))
                begin
                    cmp_pend_next = 1'b0;
                    if (!cmp_pend_reg)
                    begin
                        res_byte_next[0] = ucp_pkg::NO_MAP_BYTE;
                        res_cnt_next     = 2'd1;
                        state_next       = ST_EMIT;
                    end
                end
                else
                begin
                    tbl_rd_en       = 1'b1;
                    tbl_rd_addr     = search_cnt_reg[IDX_W-1:0];
                    cmp_pend_next   = 1'b1;
                    cmp_idx_next    = search_cnt_reg[IDX_W-1:0];
                    search_cnt_next = search_cnt_reg + 1'b1;
                end
            end
            ST_LOOKUP:
            begin
                if (enc_value < 16'h0080)
                begin
                    res_byte_next[0] = enc_value[7:0];
                    res_cnt_next     = 2'd1;
                end
                else if (enc_value < 16'h0800)
                begin
                    res_byte_next[0] = {3'b110, enc_value[10:6]};
                    res_byte_next[1] = {2'b10, enc_value[5:0]};
                    res_cnt_next     = 2'd2;
                end
                else
                begin
                    res_byte_next[0] = {4'b1110, enc_value[15:12]};
                    res_byte_next[1] = {2'b10, enc_value[11:6]};
                    res_byte_next[2] = {2'b10, enc_value[5:0]};
                    res_cnt_next     = 2'd3;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg[res_idx_reg];
                    out_end_next   = res_end_reg[res_idx_reg];
                    out_last_next  = (res_idx_reg == res_cnt_reg - 2'd1);
                    res_idx_next   = res_idx_reg + 2'd1;
                    if (res_idx_reg == res_cnt_reg - 2'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_cnt_reg    <= 2'd0;
            res_idx_reg    <= 2'd0;
            search_cnt_reg <= '0;
            cmp_pend_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_cnt_reg    <= res_cnt_next;
            res_idx_reg    <= res_idx_next;
            search_cnt_reg <= search_cnt_next;
            cmp_pend_reg   <= cmp_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_byte_reg <= res_byte_next;
        res_end_reg  <= res_end_next;
        cmp_idx_reg  <= cmp_idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_end_reg  <= out_end_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.out_byte    = out_byte_reg;
    assign rsp.last_of_run = out_last_reg;
    assign rsp.string_end  = out_end_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (res_idx_reg < res_cnt_reg))
        else $error("emission index past result count");

    a_end_is_last_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.string_end) |-> (rsp.last_of_run && (rsp.out_byte == '0)))
        else $error("string end on a non-final or nonzero byte");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (search_cnt_reg <= CNT_W'(TABLE_ENTRIES)))
        else $error("table search ran past the last entry");

    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SEARCH) && (state_next == ST_EMIT)) |=> !cmp_pend_reg)
        else $error("compare still pending after search ended");
`endif

endmodule
